[rtl/i2da_pkg.sv]
// Shared constants and types for the integer to decimal ASCII converter.
package i2da_pkg;

  localparam int DATA_W           = 32;
  localparam int DEC_DIGITS       = 10;
  localparam int DIGIT_W          = 4;
  localparam int POS_W            = 4;
  localparam int CHAR_W           = 8;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 4;
  localparam int BIT_CNT_W        = $clog2(DATA_W);

  localparam logic [DIGIT_W-1:0] MAX_DIGITS_BOUND = 4'd10;
  localparam logic [DIGIT_W-1:0] MAX_DIGITS_RESET = 4'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITS  = 1'b1;

  typedef struct packed {
    logic                neg;
    logic [DIGIT_W-1:0]  limit;
  } job_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_COUNT,
    EM_RUN
  } em_state_t;

endpackage

[rtl/i2da_dabble.sv]
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module i2da_dabble (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [i2da_pkg::DATA_W-1:0]   mag,
  output logic [i2da_pkg::DIGIT_W-1:0]  digits [i2da_pkg::DEC_DIGITS],
  output logic                          done
);
  import i2da_pkg::*;

  logic [DATA_W-1:0]    bin;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 active;
  logic [DIGIT_W-1:0]   adj       [DEC_DIGITS];
  logic [DIGIT_W-1:0]   bcd_next  [DEC_DIGITS];

  // add-3 correction per digit, then shift left by one with carry from below
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
    bcd_next[0] = {adj[0][DIGIT_W-2:0], bin[DATA_W-1]};
    for (int i = 1; i < DEC_DIGITS; i++) begin
      bcd_next[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        active  <= 1'b1;
        bit_cnt <= '0;
      end else if (active) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == BIT_CNT_W'(DATA_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin <= mag;
      for (int i = 0; i < DEC_DIGITS; i++) begin
        digits[i] <= '0;
      end
    end else if (active) begin
      bin <= {bin[DATA_W-2:0], 1'b0};
      for (int i = 0; i < DEC_DIGITS; i++) begin
        digits[i] <= bcd_next[i];
      end
    end
  end

endmodule

[rtl/i2da_emit.sv]
// Character sequencer: sizes the digit run and emits sign and digits, one per cycle.
module i2da_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          conv_done,
  input  i2da_pkg::job_t                job,
  input  logic [i2da_pkg::DIGIT_W-1:0]  digits [i2da_pkg::DEC_DIGITS],
  output logic                          out_valid,
  output logic [i2da_pkg::CHAR_W-1:0]   character,
  output logic [i2da_pkg::POS_W-1:0]    position,
  output logic                          last_char,
  output logic                          fin
);
  import i2da_pkg::*;

  em_state_t          state, state_next;
  logic [DIGIT_W-1:0] idx, idx_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic               neg_pend, neg_pend_next;
  logic [DIGIT_W-1:0] nd;
  logic [DIGIT_W-1:0] cnt;
  logic               out_valid_next, last_char_next;
  logic [CHAR_W-1:0]  character_next;

  // significant digit count, then clamp to the limit; zero keeps one digit
  always_comb begin
    nd = '0;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (digits[i] != '0) nd = DIGIT_W'(i + 1);
    end
    if (nd == '0)            cnt = 4'd1;
    else if (nd < job.limit) cnt = nd;
    else                     cnt = job.limit;
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    pos_next       = pos;
    neg_pend_next  = neg_pend;
    out_valid_next = 1'b0;
    last_char_next = 1'b0;
    character_next = character;
    fin            = 1'b0;
    case (state)
      EM_IDLE: begin
        if (conv_done) state_next = EM_COUNT;
      end
      EM_COUNT: begin
        idx_next      = cnt - 1'b1;
        pos_next      = '0;
        neg_pend_next = job.neg;
        state_next    = EM_RUN;
      end
      EM_RUN: begin
        out_valid_next = 1'b1;
        pos_next       = pos + 1'b1;
        if (neg_pend) begin
          character_next = CHAR_MINUS;
          neg_pend_next  = 1'b0;
        end else begin
          character_next = CHAR_ZERO + CHAR_W'(digits[idx]);
          idx_next       = idx - 1'b1;
          if (idx == '0) begin
            last_char_next = 1'b1;
            fin            = 1'b1;
            state_next     = EM_IDLE;
          end
        end
      end
      default: state_next = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    pos       <= pos_next;
    neg_pend  <= neg_pend_next;
    character <= character_next;
    last_char <= last_char_next;
    if (state == EM_RUN) position <= pos;
  end

endmodule

[rtl/integer_to_decimal_ascii_core.sv]
// Top level: 32-bit integer to decimal ASCII text, one character per strobe.
//
//  Channel   Signals                          Direction  Handshake
//  command   start, busy, value               in         start & !busy
//  result    out_valid, character, position,  out        out_valid, one cycle
//            last_char
//  config    cfg_we, cfg_index, cfg_data      in         cfg_we
//
// A transaction is taken when start is high and busy is low. The magnitude
// is converted by a bit-serial shift-and-add-3 unit, one input bit per
// cycle. The dabble unit's done strobe hands the digits over and the
// EM_COUNT state sizes the digit run, then one character leaves per cycle.
// Busy stays up until the final character is chosen, so no new value is
// taken mid-item; the conversion loop takes the bulk of that time.
// Reset (rst, synchronous) clears the control state and loads
// signed_mode = 0, max_digits = 10. The receiver cannot stall: each
// character is on the ports for exactly one cycle under out_valid.
module integer_to_decimal_ascii_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [i2da_pkg::DATA_W-1:0]      value,
  input  logic                             cfg_we,
  input  logic [i2da_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2da_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_valid,
  output logic [i2da_pkg::CHAR_W-1:0]      character,
  output logic [i2da_pkg::POS_W-1:0]       position,
  output logic                             last_char
);
  import i2da_pkg::*;

  logic               signed_mode;
  logic [DIGIT_W-1:0] max_digits;
  logic               accept;
  logic               neg_in;
  logic [DATA_W-1:0]  mag;
  logic [DIGIT_W-1:0] limit_in;
  job_t               job;
  logic [DIGIT_W-1:0] digits [DEC_DIGITS];
  logic               conv_done;
  logic               fin;

  assign accept = start & ~busy;

  // sign and magnitude; the most negative value wraps to 2^31 as unsigned
  assign neg_in = signed_mode & value[DATA_W-1];
  assign mag    = neg_in ? (DATA_W'(0) - value) : value;

  // digit limit: zero acts as one, anything above the bound acts as the bound
  always_comb begin
    if (max_digits == '0)                  limit_in = 4'd1;
    else if (max_digits > MAX_DIGITS_BOUND) limit_in = MAX_DIGITS_BOUND;
    else                                    limit_in = max_digits;
  end

  // config registers; both index values are decoded, so the case default is never reached
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
      max_digits  <= MAX_DIGITS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIGNED_MODE: signed_mode <= cfg_data[0];
        CFG_MAX_DIGITS:  max_digits  <= cfg_data;
        default: ;
      endcase
    end
  end

  // busy spans from accept through the cycle that selects the final character; it is low once that character is out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (fin) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.neg   <= neg_in & (value != '0);
      job.limit <= limit_in;
    end
  end

  i2da_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .mag    (mag),
    .digits (digits),
    .done   (conv_done)
  );

  i2da_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .conv_done (conv_done),
    .job       (job),
    .digits    (digits),
    .out_valid (out_valid),
    .character (character),
    .position  (position),
    .last_char (last_char),
    .fin       (fin)
  );

endmodule
